// ===== rtl/sem_pkg.sv =====
// Package: constants, types and helpers shared by the Sobel edge magnitude block.
package sem_pkg;
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight) + 1;
    localparam int CfgIdxW    = 1;
    localparam int CfgDataW   = 13;
    localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
    localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
    localparam logic [10:0] ResetWidth  = 11'd640;
    localparam logic [12:0] ResetHeight = 13'd480;
    localparam logic CmdPixel = 1'b0;
    localparam logic CmdFlush = 1'b1;

    typedef enum logic [1:0] {
        t_idle_st = 2'd0,
        t_read_st = 2'd1,
        t_calc_st = 2'd2,
        t_out_st  = 2'd3
    } t_state;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic       has_result;
        logic       busy_sqrt;
    } t_status;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } t_out_beat;
endpackage

// ===== rtl/sem_stream_if.sv =====
// Interface: valid/ready channel carrying one beat of a payload type.
interface sem_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sobel_edge_magnitude_top.sv =====
// Sobel edge magnitude, RGB 3x3, raster stream.
// One beat passes through read and compute, and then through output when it yields
// a result (9 root steps plus a rounding step); output stalls hold it in output.
// One beat at a time, set by the bit-serial square roots, which share one step counter.
// Results trail input by image_width+1 beats; flush beats drain the last row.
// Synchronous active-low reset: 640x480, counters and window zero, line buffers undefined.
module sobel_edge_magnitude_top (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [sem_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CfgDataW-1:0] i_cfg_data,
    sem_stream_if.sink   i_in,
    sem_stream_if.source o_out
);
    import sem_pkg::*;
    t_cmd    cmd;
    t_status status;
    t_out_beat out_beat;

    sem_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_status(status), .o_cmd(cmd)
    );

    sem_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(i_in.data), .i_cmd(cmd), .o_status(status), .o_out(out_beat)
    );

    assign o_out.data = out_beat;
endmodule

// ===== rtl/sem_ctrl.sv =====
// Controller: sequences one beat through read, compute and output.
module sem_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sem_pkg::t_status    i_status,
    output sem_pkg::t_cmd       o_cmd
);
    import sem_pkg::*;
    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle_st: if (i_in_valid) n_state = t_read_st;
            t_read_st: n_state = t_calc_st;
            t_calc_st: begin
                if (!i_status.busy_sqrt)
                    n_state = i_status.has_result ? t_out_st : t_idle_st;
            end
            t_out_st: if (i_out_ready) n_state = t_idle_st;
            default: n_state = t_idle_st;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready  = (r_state == t_idle_st);
        o_out_valid = (r_state == t_out_st);
        o_cmd.load  = (r_state == t_idle_st) && i_in_valid;
        o_cmd.step  = (r_state == t_read_st);
        o_cmd.emit  = (r_state == t_out_st) && i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_idle_st;
        else          r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_out_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == t_calc_st) else $error("bad out");
    a_read_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == t_read_st) else $error("bad load");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("both sides");
`endif
endmodule

// ===== rtl/sem_datapath.sv =====
// Datapath: line buffers, window, counters, Sobel sums and iterative square roots.
module sem_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [sem_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CfgDataW-1:0] i_cfg_data,
    input  sem_pkg::t_in_beat    i_in,
    input  sem_pkg::t_cmd        i_cmd,
    output sem_pkg::t_status     o_status,
    output sem_pkg::t_out_beat   o_out
);
    import sem_pkg::*;

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [ColW:0] w_eff;
    logic [RowW-1:0] h_eff;
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;
    logic [23:0] r_win [9];
    logic [23:0] r_in_pix;
    logic        r_in_flush;
    logic [23:0] mem_up [MaxWidth];
    logic [23:0] mem_lo [MaxWidth];
    logic [23:0] r_top, r_mid;
    logic        r_has;
    logic [RowW-1:0] r_r;
    logic [ColW-1:0] r_c;
    logic        r_last;
    logic        draining, flush_skip;
    logic [ColW-1:0] col_c;

    // Effective frame size, clamped
    always_comb begin
        if (r_width == 11'd0) w_eff = (ColW+1)'(1);
        else if (r_width > 11'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
        else w_eff = (ColW+1)'(r_width);
        if (r_height == 13'd0) h_eff = RowW'(1);
        else if (r_height > 13'(MaxHeight)) h_eff = RowW'(MaxHeight);
        else h_eff = RowW'(r_height);
    end

    assign draining   = (r_row >= h_eff);
    assign flush_skip = !draining && r_in_flush;
    assign col_c      = ((ColW+1)'(r_col) >= w_eff) ? '0 : r_col;

    // Capture beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_pix   <= {i_in.in_red, i_in.in_green, i_in.in_blue};
            r_in_flush <= (i_in.cmd == CmdFlush);
        end
    end

    // Sqrt / magnitude units
    logic [7:0]  r_mag [3];
    logic [8:0]  r_bit;
    logic        r_busy;
    logic [23:0] cur_pix;
    logic signed [11:0] gx [3];
    logic signed [11:0] gy [3];
    logic signed [21:0] gx_w [3];
    logic signed [21:0] gy_w [3];
    logic [22:0] sq_sum [3];
    logic [23:0] wv [9];
    logic cl_ok, cr_ok, rt_ok, rb_ok;

    assign cur_pix = draining ? 24'd0 : r_in_pix;

    // Read and write line buffers
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && !flush_skip) begin
            mem_up[col_c] <= r_mid;
            mem_lo[col_c] <= cur_pix;
        end
        r_top <= mem_up[col_c];
        r_mid <= mem_lo[col_c];
    end

    // Window after this shift, used for the sums next cycle via r_win
    always_comb begin
        cl_ok = (r_c != '0);
        cr_ok = ((ColW+1)'(r_c) + (ColW+1)'(1) < w_eff);
        rt_ok = (r_r != '0);
        rb_ok = (r_r + RowW'(1) < h_eff);
        for (int k = 0; k < 9; k++) begin
            wv[k] = r_win[k];
            if ((k < 3 && !cl_ok) || (k > 5 && !cr_ok) ||
                (k % 3 == 0 && !rt_ok) || (k % 3 == 2 && !rb_ok))
                wv[k] = '0;
        end
        for (int ch = 0; ch < 3; ch++) begin
            gx[ch] = - $signed({4'd0, wv[0][ch*8 +: 8]}) - 12'sd2 * $signed({4'd0, wv[1][ch*8 +: 8]})
                     - $signed({4'd0, wv[2][ch*8 +: 8]}) + $signed({4'd0, wv[6][ch*8 +: 8]})
                     + 12'sd2 * $signed({4'd0, wv[7][ch*8 +: 8]}) + $signed({4'd0, wv[8][ch*8 +: 8]});
            gy[ch] = - $signed({4'd0, wv[0][ch*8 +: 8]}) - 12'sd2 * $signed({4'd0, wv[3][ch*8 +: 8]})
                     - $signed({4'd0, wv[6][ch*8 +: 8]}) + $signed({4'd0, wv[2][ch*8 +: 8]})
                     + 12'sd2 * $signed({4'd0, wv[5][ch*8 +: 8]}) + $signed({4'd0, wv[8][ch*8 +: 8]});
            // Widen before squaring so the products keep all their bits
            gx_w[ch] = 22'(gx[ch]);
            gy_w[ch] = 22'(gy[ch]);
            sq_sum[ch] = 23'($unsigned(gx_w[ch] * gx_w[ch])) +
                         23'($unsigned(gy_w[ch] * gy_w[ch]));
        end
    end

    logic [22:0] r_s [3];
    logic        r_sum_pend;
    logic [7:0]  trial [3];

    // Config, counters, window, sums and bitwise square root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= ResetWidth; r_height <= ResetHeight;
            r_col <= '0; r_row <= '0; r_has <= 1'b0;
            r_busy <= 1'b0; r_sum_pend <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == RegWidth) r_width <= i_cfg_data[10:0];
                else r_height <= i_cfg_data;
                r_col <= '0; r_row <= '0;
                for (int k = 0; k < 9; k++) r_win[k] <= '0;
            end
            r_sum_pend <= 1'b0;
            if (i_cmd.step) begin
                r_has <= 1'b0;
                if (!flush_skip) begin
                    for (int k = 0; k < 6; k++) r_win[k] <= r_win[k+3];
                    r_win[6] <= r_top; r_win[7] <= r_mid; r_win[8] <= cur_pix;
                    if ((ColW+1)'(col_c) + (ColW+1)'(1) >= w_eff) begin
                        r_col <= '0; r_row <= r_row + RowW'(1);
                    end else r_col <= col_c + ColW'(1);
                    if (r_row >= RowW'(2) || (r_row == RowW'(1) && col_c != '0)) begin
                        r_has <= 1'b1; r_sum_pend <= 1'b1;
                        if (col_c != '0) begin
                            r_r <= r_row - RowW'(1); r_c <= col_c - ColW'(1);
                        end else begin
                            r_r <= r_row - RowW'(2); r_c <= ColW'(w_eff - (ColW+1)'(1));
                        end
                    end
                end
            end
            if (r_sum_pend) begin
                r_last <= (r_r + RowW'(1) >= h_eff) &&
                          ((ColW+1)'(r_c) + (ColW+1)'(1) >= w_eff);
                for (int ch = 0; ch < 3; ch++) begin
                    r_s[ch]   <= sq_sum[ch];
                    r_mag[ch] <= '0;
                end
                r_bit <= 9'h100; r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_bit == 9'd0) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        if (r_s[ch] > 23'(65280)) r_mag[ch] <= 8'd255;
                        else if (r_s[ch] > 23'(r_mag[ch]) * 23'(r_mag[ch]) + 23'(r_mag[ch]))
                            r_mag[ch] <= r_mag[ch] + 8'd1;
                    end
                    r_busy <= 1'b0;
                end else begin
                    for (int ch = 0; ch < 3; ch++)
                        if (23'(trial[ch]) * 23'(trial[ch]) <= r_s[ch]) r_mag[ch] <= trial[ch];
                    r_bit <= r_bit >> 1;
                end
            end
            if (i_cmd.emit && r_last) begin
                r_col <= '0; r_row <= '0;
                for (int k = 0; k < 9; k++) r_win[k] <= '0;
            end
        end
    end

    always_comb for (int ch = 0; ch < 3; ch++) trial[ch] = r_mag[ch] | r_bit[8:1];

    assign o_status.has_result = r_has;
    assign o_status.busy_sqrt  = r_busy || r_sum_pend || i_cmd.step;
    assign o_out.out_red    = r_mag[2];
    assign o_out.out_green  = r_mag[1];
    assign o_out.out_blue   = r_mag[0];
    assign o_out.frame_last = r_last;

`ifndef SYNTHESIS
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ColW+1)'(r_col) <= w_eff || $past(i_cfg_we)) else $error("col range");
    a_sqrt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_pend |=> r_busy) else $error("sqrt start");
    a_has_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_pend |-> r_has) else $error("sum w/o result");
`endif
endmodule

// ===== sim/sobel_edge_magnitude_checker.sv =====
// Checker for the Sobel edge magnitude block: predicts each output beat and compares.
`timescale 1ns / 1ps
module sobel_edge_magnitude_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [sem_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  sem_pkg::t_in_beat  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  sem_pkg::t_out_beat i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    import sem_pkg::*;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] upper_row [MaxWidth];
    logic [23:0] lower_row [MaxWidth];
    logic [23:0] win [9];
    int unsigned col_pos, row_pos;
    t_out_beat expected_pixels [$];

    assign o_pending = expected_pixels.size();

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MaxWidth) return MaxWidth;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MaxHeight) return MaxHeight;
        return height_reg;
    endfunction

    // Rounded square root, clamped to 255
    function automatic logic [7:0] round_root(int unsigned s);
        int unsigned root;
        if (s > 65280) return 8'd255;
        root = 0;
        while ((root + 1) * (root + 1) <= s) root++;
        if (s > root * root + root) root++;
        return (root > 255) ? 8'd255 : root[7:0];
    endfunction

    function automatic logic [7:0] edge_mag(int shift, int unsigned r, int unsigned c,
                                            int unsigned w, int unsigned h);
        int gx, gy, v, kx, ky;
        bit col_ok, row_ok;
        gx = 0;
        gy = 0;
        for (int i = 0; i < 3; i++) begin
            col_ok = (i == 0) ? (c > 0) : (i == 2) ? (c + 1 < w) : 1'b1;
            for (int j = 0; j < 3; j++) begin
                row_ok = (j == 0) ? (r > 0) : (j == 2) ? (r + 1 < h) : 1'b1;
                if (col_ok && row_ok) begin
                    v = (win[i * 3 + j] >> shift) & 8'hFF;
                    // column weight along x, row weight along y
                    kx = (i - 1) * ((j == 1) ? 2 : 1);
                    ky = (j - 1) * ((i == 1) ? 2 : 1);
                    gx += kx * v;
                    gy += ky * v;
                end
            end
        end
        return round_root(gx * gx + gy * gy);
    endfunction

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int k = 0; k < 9; k++) win[k] = '0;
    endtask

    task automatic predict_beat(t_in_beat b);
        int unsigned w, h, rr, cc, r, c;
        logic [23:0] pix, top, mid;
        t_out_beat res;
        w = eff_width();
        h = eff_height();
        rr = row_pos;
        cc = (col_pos >= w) ? 0 : col_pos;
        pix = '0;
        if (rr < h) begin
            if (b.cmd == CmdFlush) return;
            pix = {b.in_red, b.in_green, b.in_blue};
        end
        top = upper_row[cc];
        mid = lower_row[cc];
        upper_row[cc] = mid;
        lower_row[cc] = pix;
        for (int k = 0; k < 6; k++) win[k] = win[k + 3];
        win[6] = top;
        win[7] = mid;
        win[8] = pix;
        if (cc + 1 >= w) begin
            col_pos = 0;
            row_pos = rr + 1;
        end else begin
            col_pos = cc + 1;
        end
        if (!(rr >= 2 || (rr == 1 && cc >= 1))) return;
        if (cc >= 1) begin
            r = rr - 1;
            c = cc - 1;
        end else begin
            r = rr - 2;
            c = w - 1;
        end
        res.out_red    = edge_mag(16, r, c, w, h);
        res.out_green  = edge_mag(8, r, c, w, h);
        res.out_blue   = edge_mag(0, r, c, w, h);
        res.frame_last = (r + 1 >= h) && (c + 1 >= w);
        expected_pixels.push_back(res);
        if (res.frame_last) restart_frame();
    endtask

    // Track config, predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            width_reg  <= ResetWidth;
            height_reg <= ResetHeight;
            restart_frame();
            expected_pixels.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == RegWidth) width_reg <= i_cfg_data[10:0];
                else height_reg <= i_cfg_data;
                restart_frame();
            end
            if (i_in_valid && i_in_ready) predict_beat(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected r%0d g%0d b%0d l%0d got r%0d g%0d b%0d l%0d",
                                 $time, want.out_red, want.out_green, want.out_blue,
                                 want.frame_last, i_out_data.out_red, i_out_data.out_green,
                                 i_out_data.out_blue, i_out_data.frame_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/sobel_edge_magnitude_top_tb.sv =====
// Testbench top: drives frames and config into the Sobel block and reports the verdict.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top_tb;
    import sem_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    int fail_count, pending_count;
    int unsigned cycle_count = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;
    int pixels_sent = 0;

    sem_stream_if #(.T(t_in_beat))  pix_in ();
    sem_stream_if #(.T(t_out_beat)) pix_out ();

    sobel_edge_magnitude_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(pix_in.sink), .o_out(pix_out.source)
    );

    sobel_edge_magnitude_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(pix_in.valid), .i_in_ready(pix_in.ready), .i_in_data(pix_in.data),
        .i_out_valid(pix_out.valid), .i_out_ready(pix_out.ready),
        .i_out_data(pix_out.data), .o_fail_count(fail_count), .o_pending(pending_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        pix_in.valid = 1'b0;
        pix_in.data = '0;
        pix_out.ready = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) pix_out.ready <= 1'b0;
        else pix_out.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("sobel_edge_magnitude_top_tb failed");
            $finish;
        end
    end

    // Send one beat, idling at random beforehand; valid stays up after the beat
    task automatic send_beat(logic cmd, logic [23:0] rgb);
        while (!calm && $urandom_range(99) < 34) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data <= {cmd, rgb};
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[CfgDataW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, then wait for every expected beat to come out
    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_rgb(int mode);
        case (mode)
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return {$urandom} & 24'hFFFFFF;
        endcase
    endfunction

    // One frame: pixels, with stray flushes when noisy, then a drain tail
    task automatic run_frame(int unsigned w, int unsigned h, int mode, bit noisy);
        for (int k = 0; k < w * h; k++) begin
            if (noisy && $urandom_range(19) == 0) send_beat(CmdFlush, pick_rgb(2));
            send_beat(CmdPixel, pick_rgb(mode == 3 ? $urandom_range(2) : mode));
        end
        // Drain with flushes, sometimes pixels that act as flushes
        for (int k = 0; k < w + 1; k++)
            send_beat(noisy && $urandom_range(3) == 0 ? CmdPixel : CmdFlush, pick_rgb(2));
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(RegWidth, w);
        write_reg(RegHeight, h);
    endtask

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        return (v == 0) ? 1 : (v > hi) ? hi : v;
    endfunction

    initial begin
        int unsigned w, h;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: tiny frames, full pixels, out-of-range sizes
        set_size(0, 0);
        run_frame(1, 1, 1, 1'b0);
        wait_drained();
        set_size(3, 3);
        run_frame(3, 3, 1, 1'b0);
        wait_drained();
        // Oversized width and height: first row wraps at the clamped width
        set_size(2047, 8191);
        for (int k = 0; k < 1030; k++) send_beat(CmdPixel, pick_rgb(2));
        wait_drained();
        // Long receiver hold-off while the sender keeps offering
        set_size(4, 4);
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            run_frame(4, 4, 3, 1'b0);
        join
        wait_drained();
        // Random frames, small
        while (pixels_sent < 1950) begin
            w = $urandom_range(12);
            h = $urandom_range(8);
            calm = ($urandom_range(5) == 0);
            set_size(w, h);
            repeat ($urandom_range(2) + 1)
                run_frame(clamp(w, MaxWidth), clamp(h, MaxHeight), 3, 1'b1);
            wait_drained();
        end
        wait_drained();
        if (fail_count == 0) $display("sobel_edge_magnitude_top_tb passed");
        else $display("sobel_edge_magnitude_top_tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sem_pkg.sv
rtl/sem_stream_if.sv
rtl/sem_ctrl.sv
rtl/sem_datapath.sv
rtl/sobel_edge_magnitude_top.sv
sim/sobel_edge_magnitude_checker.sv
sim/sobel_edge_magnitude_top_tb.sv
